/* hdl/mmps_pkg.sv */
// mmps_pkg: types, codes and default sizes for the margin preserving swap engine
// used by matrix_margin_preserving_swap_top and its checker; depends on nothing
package mmps_pkg;

   localparam int DEF_MAX_ROWS  = 64;
   localparam int DEF_MAX_COLS  = 64;
   localparam int DEF_CELL_BITS = 16;

   localparam int IDX_W   = 6;
   localparam int CSR_W   = 13;
   localparam int ROWS_W  = 7;
   localparam int FILL_OW = 13;
   localparam int TOT_OW  = 28;
   localparam int SQ_OW   = 44;
   localparam int VAL_OW  = 16;
   localparam int AMT_OW  = 17;

   typedef enum logic [1:0] {
      REQ_WRITE  = 2'd0,
      REQ_READ   = 2'd1,
      REQ_SWAP   = 2'd2,
      REQ_UNUSED = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_BAD_IDX = 2'd1,
      STAT_REFUSED = 2'd2,
      STAT_SPARE   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      MODE_TRIAL   = 2'd0,
      MODE_QUASI   = 2'd1,
      MODE_NEUTRAL = 2'd2,
      MODE_STEER   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_SWAP_MODE   = 2'd0,
      CSR_NUM_ROWS    = 2'd1,
      CSR_NUM_COLS    = 2'd2,
      CSR_TARGET_FILL = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD,
      ST_CAP,
      ST_DECIDE,
      ST_CHECK,
      ST_UPD_A,
      ST_UPD_B,
      ST_UPD_C,
      ST_DONE
   } state_type;

endpackage

/* hdl/matrix_margin_preserving_swap_top.sv */
// matrix_margin_preserving_swap_top: count matrix with running total, squares and fill,
// cell write/read and four kinds of 2x2 margin preserving swap; depends on mmps_pkg

// The block keeps the matrix in one memory with separate ports (one write, one registered read a
// cycle) and walks each item through a small sequencer with one shared squaring multiplier.
// After reset a clearing pass over every address zeroes the memory; req_ready stays low
// meanwhile, csr writes are taken as ever.
// A read fetches its cell and decides; a write also runs the update steps once. A swap fetches
// all four cells, decides, checks for overflow, then runs the three update steps (multiplier,
// running sums) per changed cell; a skipped swap ends at the check, and a bad index skips all steps.
// One item is in work at a time; the next item is taken while a result waits at rsp_.
module matrix_margin_preserving_swap_top #(
   parameter int MAX_ROWS  = mmps_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS  = mmps_pkg::DEF_MAX_COLS,
   parameter int CELL_BITS = mmps_pkg::DEF_CELL_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [1:0]                           csr_index,
   input  logic [mmps_pkg::CSR_W-1:0]           csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_type,
   input  logic [mmps_pkg::IDX_W-1:0]           req_row_first,
   input  logic [mmps_pkg::IDX_W-1:0]           req_row_second,
   input  logic [mmps_pkg::IDX_W-1:0]           req_col_first,
   input  logic [mmps_pkg::IDX_W-1:0]           req_col_second,
   input  logic [mmps_pkg::VAL_OW-1:0]          req_write_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [mmps_pkg::VAL_OW-1:0]          rsp_read_value,
   output logic                                 rsp_swapped,
   output logic signed [mmps_pkg::AMT_OW-1:0]   rsp_swap_amount,
   output logic [mmps_pkg::TOT_OW-1:0]          rsp_matrix_total,
   output logic [mmps_pkg::SQ_OW-1:0]           rsp_sum_of_squares,
   output logic [mmps_pkg::FILL_OW-1:0]         rsp_fill_count,
   output logic                                 rsp_converged,
   output logic [1:0]                           rsp_status
);

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ADDR_W = ROW_W + COL_W;
   localparam int DEPTH  = 2 ** ADDR_W;
   localparam int TOT_W  = CELL_BITS + ADDR_W + 1;
   localparam int SQ_W   = 2 * CELL_BITS + ADDR_W + 1;
   localparam int FILL_W = ADDR_W + 1;
   localparam int E_W    = CELL_BITS + 1;
   localparam int NV_W   = CELL_BITS + 2;

   // cell memory, cleared by the pass after reset
   logic [CELL_BITS-1:0] mem [DEPTH];
   logic [CELL_BITS-1:0] rd_data_ff;
   logic [ADDR_W-1:0]    rd_addr, mem_waddr;
   logic [CELL_BITS-1:0] mem_wdata;
   logic                 mem_we;

   // sequencer
   mmps_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic [1:0]          k_ff, k_in;
   logic [1:0]          last_ff, last_in;

   // configuration
   logic [1:0]                  mode_ff;
   logic [mmps_pkg::ROWS_W-1:0] rows_ff, cols_ff;
   logic [mmps_pkg::CSR_W-1:0]  target_ff;

   // item fields held during the work
   logic [1:0]                 kind_ff, kind_in;
   logic [mmps_pkg::IDX_W-1:0] r1_ff, r2_ff, c1_ff, c2_ff;
   logic [CELL_BITS-1:0]       wv_ff;

   // cell values before and after, move amount, status
   logic [CELL_BITS-1:0]   v_ff [4];
   logic [CELL_BITS-1:0]   v_in [4];
   logic [CELL_BITS-1:0]   nv_ff [4];
   logic [CELL_BITS-1:0]   nv_in [4];
   logic signed [E_W-1:0]  e_ff, e_in;
   logic                   swapped_ff, swapped_in;
   logic                   is_read_ff, is_read_in;
   logic [1:0]             status_ff, status_in;

   // running sums and the shared squaring unit
   logic [TOT_W-1:0]       total_ff, total_in;
   logic [SQ_W-1:0]        sq_ff, sq_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [2*CELL_BITS-1:0] prod_ff;
   logic [CELL_BITS-1:0]   mul_op;

   // result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [mmps_pkg::VAL_OW-1:0]         o_read_ff, o_read_in;
   logic                                o_swapped_ff, o_swapped_in;
   logic signed [mmps_pkg::AMT_OW-1:0]  o_amt_ff, o_amt_in;
   logic [mmps_pkg::TOT_OW-1:0]         o_tot_ff, o_tot_in;
   logic [mmps_pkg::SQ_OW-1:0]          o_sq_ff, o_sq_in;
   logic [mmps_pkg::FILL_OW-1:0]        o_fill_ff, o_fill_in;
   logic                                o_conv_ff, o_conv_in;
   logic [1:0]                          o_status_ff, o_status_in;

   logic accept, out_free, bad_idx;
   logic [ADDR_W-1:0] cell_addr [4];

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // index check on the incoming item
   always_comb begin
      logic r1_ok, r2_ok, c1_ok, c2_ok;
      r1_ok = (7'(req_row_first)  < rows_ff) && (int'(req_row_first)  < MAX_ROWS);
      r2_ok = (7'(req_row_second) < rows_ff) && (int'(req_row_second) < MAX_ROWS);
      c1_ok = (7'(req_col_first)  < cols_ff) && (int'(req_col_first)  < MAX_COLS);
      c2_ok = (7'(req_col_second) < cols_ff) && (int'(req_col_second) < MAX_COLS);
      bad_idx = 1'b0;
      unique case (req_type)
         mmps_pkg::REQ_WRITE, mmps_pkg::REQ_READ: bad_idx = !(r1_ok && c1_ok);
         mmps_pkg::REQ_SWAP: bad_idx = !(r1_ok && r2_ok && c1_ok && c2_ok) ||
                                       (req_row_first == req_row_second) ||
                                       (req_col_first == req_col_second);
         default: bad_idx = 1'b0;
      endcase
   end

   // cells a, b, c, d of the submatrix; rows and columns packed side by side
   assign cell_addr[0] = {ROW_W'(r1_ff), COL_W'(c1_ff)};
   assign cell_addr[1] = {ROW_W'(r1_ff), COL_W'(c2_ff)};
   assign cell_addr[2] = {ROW_W'(r2_ff), COL_W'(c1_ff)};
   assign cell_addr[3] = {ROW_W'(r2_ff), COL_W'(c2_ff)};

   // move rules, evaluated on the four read cells
   logic signed [E_W-1:0] e_rule;
   always_comb begin
      logic [CELL_BITS-1:0] a, b, c, d, min_bc, min_ad;
      logic [CELL_BITS:0]   sum_ad, sum_bc;
      logic [2:0]           nz;
      logic signed [1:0]    fc;
      a = v_ff[0]; b = v_ff[1]; c = v_ff[2]; d = v_ff[3];
      min_bc = (b < c) ? b : c;
      min_ad = (a < d) ? a : d;
      sum_ad = (CELL_BITS+1)'(a) + (CELL_BITS+1)'(d);
      sum_bc = (CELL_BITS+1)'(b) + (CELL_BITS+1)'(c);
      nz = 3'(a != '0) + 3'(b != '0) + 3'(c != '0) + 3'(d != '0);
      fc = 2'sd0;
      e_rule = '0;
      unique case (mode_ff)
         mmps_pkg::MODE_TRIAL: begin
            if (a == '0 && b == CELL_BITS'(1) && c == CELL_BITS'(1) && d == '0)
               e_rule = E_W'(1);
            else if (a == CELL_BITS'(1) && b == '0 && c == '0 && d == CELL_BITS'(1))
               e_rule = -E_W'(1);
         end
         mmps_pkg::MODE_QUASI: begin
            if (a != '0 && d != '0 && (CELL_BITS+2)'(sum_ad) >= (CELL_BITS+2)'(sum_bc) + 2)
               e_rule = -E_W'(1);
            else if (b != '0 && c != '0 &&
                     (CELL_BITS+2)'(sum_bc) >= (CELL_BITS+2)'(sum_ad) + 2)
               e_rule = E_W'(1);
         end
         mmps_pkg::MODE_NEUTRAL: begin
            if (nz == 3'd2) begin
               if (a == d && b == c)
                  e_rule = (b != '0) ? $signed({1'b0, b}) : -$signed({1'b0, a});
            end else if (nz == 3'd3) begin
               if (a != d && b != c)
                  e_rule = (a == '0 || d == '0) ? $signed({1'b0, min_bc})
                                                : -$signed({1'b0, min_ad});
            end
         end
         default: begin
            // steer: largest move, then keep it only when fill stays or heads toward target
            if (nz == 3'd2) begin
               if (b != '0 && c != '0) begin
                  if (b != c) fc = 2'sd1;
                  e_rule = $signed({1'b0, min_bc});
               end else if (a != '0 && d != '0) begin
                  if (a != d) fc = 2'sd1;
                  e_rule = -$signed({1'b0, min_ad});
               end
            end else if (nz == 3'd3) begin
               if (a == '0 || d == '0) begin
                  if (b == c) fc = -2'sd1;
                  e_rule = $signed({1'b0, min_bc});
               end else begin
                  if (a == d) fc = -2'sd1;
                  e_rule = -$signed({1'b0, min_ad});
               end
            end else if (nz == 3'd4) begin
               fc = -2'sd1;  // two or one cells emptied; only the sign matters
               e_rule = $signed({1'b0, min_bc});
            end
            if (e_rule != '0 && fc != 2'sd0 &&
                !((fc < 0 && 32'(target_ff) < 32'(fill_ff)) ||
                  (fc > 0 && 32'(target_ff) > 32'(fill_ff))))
               e_rule = '0;
         end
      endcase
   end

   // new cell values and the overflow check
   logic [NV_W-1:0] nv_full [4];
   logic            nv_ok;
   always_comb begin
      nv_full[0] = NV_W'(v_ff[0]) + NV_W'(e_ff);
      nv_full[1] = NV_W'(v_ff[1]) - NV_W'(e_ff);
      nv_full[2] = NV_W'(v_ff[2]) - NV_W'(e_ff);
      nv_full[3] = NV_W'(v_ff[3]) + NV_W'(e_ff);
      nv_ok = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (nv_full[i][NV_W-1:CELL_BITS] != 2'b00) nv_ok = 1'b0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mmps_pkg::ST_CLEAR:  if (clr_ff == ADDR_W'(DEPTH - 1)) state_in = mmps_pkg::ST_IDLE;
         mmps_pkg::ST_IDLE: begin
            if (accept) begin
               if (bad_idx || req_type == mmps_pkg::REQ_UNUSED) state_in = mmps_pkg::ST_DONE;
               else state_in = mmps_pkg::ST_RD;
            end
         end
         mmps_pkg::ST_RD:  state_in = mmps_pkg::ST_CAP;
         mmps_pkg::ST_CAP: begin
            if (kind_ff == mmps_pkg::REQ_SWAP && k_ff != 2'd3) state_in = mmps_pkg::ST_RD;
            else state_in = mmps_pkg::ST_DECIDE;
         end
         mmps_pkg::ST_DECIDE: begin
            priority case (kind_ff)
               mmps_pkg::REQ_READ:  state_in = mmps_pkg::ST_DONE;
               mmps_pkg::REQ_WRITE: state_in = mmps_pkg::ST_UPD_A;
               default:             state_in = mmps_pkg::ST_CHECK;
            endcase
         end
         mmps_pkg::ST_CHECK: begin
            if (e_ff == '0 || !nv_ok) state_in = mmps_pkg::ST_DONE;
            else state_in = mmps_pkg::ST_UPD_A;
         end
         mmps_pkg::ST_UPD_A: state_in = mmps_pkg::ST_UPD_B;
         mmps_pkg::ST_UPD_B: state_in = mmps_pkg::ST_UPD_C;
         mmps_pkg::ST_UPD_C: begin
            if (k_ff == last_ff) state_in = mmps_pkg::ST_DONE;
            else state_in = mmps_pkg::ST_UPD_A;
         end
         mmps_pkg::ST_DONE: if (out_free) state_in = mmps_pkg::ST_IDLE;
         default: state_in = mmps_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake, memory port, multiplier operand
   always_comb begin
      req_ready = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = cell_addr[k_ff];
      mem_wdata = nv_ff[k_ff];
      rd_addr   = cell_addr[k_ff];
      mul_op    = nv_ff[k_ff];
      unique case (state_ff)
         mmps_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
         end
         mmps_pkg::ST_IDLE:  req_ready = 1'b1;
         mmps_pkg::ST_UPD_A: begin
            mem_we = 1'b1;
            mul_op = v_ff[k_ff];
         end
         default: ;
      endcase
   end

   // datapath next values
   always_comb begin
      kind_in    = kind_ff;
      k_in       = k_ff;
      last_in    = last_ff;
      clr_in     = clr_ff;
      v_in       = v_ff;
      nv_in      = nv_ff;
      e_in       = e_ff;
      swapped_in = swapped_ff;
      is_read_in = is_read_ff;
      status_in  = status_ff;
      total_in   = total_ff;
      sq_in      = sq_ff;
      fill_in    = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      o_read_in    = o_read_ff;
      o_swapped_in = o_swapped_ff;
      o_amt_in     = o_amt_ff;
      o_tot_in     = o_tot_ff;
      o_sq_in      = o_sq_ff;
      o_fill_in    = o_fill_ff;
      o_conv_in    = o_conv_ff;
      o_status_in  = o_status_ff;
      unique case (state_ff)
         mmps_pkg::ST_CLEAR: clr_in = clr_ff + 1'b1;
         mmps_pkg::ST_IDLE: begin
            if (accept) begin
               kind_in    = req_type;
               k_in       = '0;
               swapped_in = 1'b0;
               is_read_in = 1'b0;
               e_in       = '0;
               status_in  = bad_idx ? mmps_pkg::STAT_BAD_IDX : mmps_pkg::STAT_OK;
            end
         end
         mmps_pkg::ST_CAP: begin
            v_in[k_ff] = rd_data_ff;
            if (kind_ff == mmps_pkg::REQ_SWAP && k_ff != 2'd3) k_in = k_ff + 1'b1;
         end
         mmps_pkg::ST_DECIDE: begin
            k_in = '0;
            priority case (kind_ff)
               mmps_pkg::REQ_READ: is_read_in = 1'b1;
               mmps_pkg::REQ_WRITE: begin
                  nv_in[0] = wv_ff;
                  last_in  = 2'd0;
               end
               default: e_in = e_rule;
            endcase
         end
         mmps_pkg::ST_CHECK: begin
            if (e_ff != '0) begin
               if (!nv_ok) begin
                  status_in = mmps_pkg::STAT_REFUSED;
               end else begin
                  for (int i = 0; i < 4; i++) nv_in[i] = nv_full[i][CELL_BITS-1:0];
                  swapped_in = 1'b1;
                  last_in    = 2'd3;
               end
            end
         end
         mmps_pkg::ST_UPD_A: begin
            total_in = total_ff - TOT_W'(v_ff[k_ff]) + TOT_W'(nv_ff[k_ff]);
            fill_in  = fill_ff - FILL_W'(v_ff[k_ff] != '0) + FILL_W'(nv_ff[k_ff] != '0);
         end
         mmps_pkg::ST_UPD_B: sq_in = sq_ff - SQ_W'(prod_ff);
         mmps_pkg::ST_UPD_C: begin
            sq_in = sq_ff + SQ_W'(prod_ff);
            if (k_ff != last_ff) k_in = k_ff + 1'b1;
         end
         mmps_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_read_in    = is_read_ff ? mmps_pkg::VAL_OW'(v_ff[0]) : '0;
               o_swapped_in = swapped_ff;
               o_amt_in     = swapped_ff ? mmps_pkg::AMT_OW'(e_ff) : '0;
               o_tot_in     = mmps_pkg::TOT_OW'(total_ff);
               o_sq_in      = mmps_pkg::SQ_OW'(sq_ff);
               o_fill_in    = mmps_pkg::FILL_OW'(fill_ff);
               o_status_in  = status_ff;
               if (mode_ff == mmps_pkg::MODE_STEER)
                  o_conv_in = (32'(fill_ff) == 32'(target_ff));
               else
                  o_conv_in = (SQ_W'(total_ff) == sq_ff);
            end
         end
         default: ;
      endcase
   end

   // memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[rd_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mmps_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         sq_ff        <= '0;
         fill_ff      <= '0;
         mode_ff      <= mmps_pkg::MODE_TRIAL;
         rows_ff      <= 7'd64;
         cols_ff      <= 7'd64;
         target_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         sq_ff        <= sq_in;
         fill_ff      <= fill_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               mmps_pkg::CSR_SWAP_MODE:   mode_ff   <= csr_write_data[1:0];
               mmps_pkg::CSR_NUM_ROWS:    rows_ff   <= csr_write_data[mmps_pkg::ROWS_W-1:0];
               mmps_pkg::CSR_NUM_COLS:    cols_ff   <= csr_write_data[mmps_pkg::ROWS_W-1:0];
               mmps_pkg::CSR_TARGET_FILL: target_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      k_ff       <= k_in;
      last_ff    <= last_in;
      v_ff       <= v_in;
      nv_ff      <= nv_in;
      e_ff       <= e_in;
      swapped_ff <= swapped_in;
      is_read_ff <= is_read_in;
      status_ff  <= status_in;
      prod_ff    <= mul_op * mul_op;
      if (accept) begin
         r1_ff <= req_row_first;
         r2_ff <= req_row_second;
         c1_ff <= req_col_first;
         c2_ff <= req_col_second;
         wv_ff <= CELL_BITS'(req_write_value);
      end
      o_read_ff    <= o_read_in;
      o_swapped_ff <= o_swapped_in;
      o_amt_ff     <= o_amt_in;
      o_tot_ff     <= o_tot_in;
      o_sq_ff      <= o_sq_in;
      o_fill_ff    <= o_fill_in;
      o_conv_ff    <= o_conv_in;
      o_status_ff  <= o_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_value     = o_read_ff;
   assign rsp_swapped        = o_swapped_ff;
   assign rsp_swap_amount    = o_amt_ff;
   assign rsp_matrix_total   = o_tot_ff;
   assign rsp_sum_of_squares = o_sq_ff;
   assign rsp_fill_count     = o_fill_ff;
   assign rsp_converged      = o_conv_ff;
   assign rsp_status         = o_status_ff;

endmodule

/* hdl/mmps_checker.sv */
// mmps_checker: port level checks on matrix_margin_preserving_swap_top results
// bound to the top level below; depends on mmps_pkg
module mmps_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_swapped,
   input logic signed [mmps_pkg::AMT_OW-1:0]  rsp_swap_amount,
   input logic [1:0]                          rsp_status
);

   // a waiting result stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a move always has a nonzero amount and ok status
   a_swap_amount: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_swapped |-> rsp_swap_amount != '0 && rsp_status == mmps_pkg::STAT_OK)
      else $error("swap reported without amount or with error status");

   // nothing moved means no amount
   a_no_move: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_swapped |-> rsp_swap_amount == '0)
      else $error("amount reported without swap");

   // status code never takes the spare value
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != mmps_pkg::STAT_SPARE)
      else $error("spare status code");

endmodule

bind matrix_margin_preserving_swap_top mmps_checker u_mmps_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_swapped     (rsp_swapped),
   .rsp_swap_amount (rsp_swap_amount),
   .rsp_status      (rsp_status)
);
